>>> hdl/zrle_pkg.sv
// shared types and constants of the zero run-length encoder
// used by zrle_front, zrle_queue, zrle_back and zero_run_length_encoder
`default_nettype none

package zrle_pkg;

    localparam int unsigned MAX_STEP_BYTES = 4;
    localparam int unsigned IDX_W          = $clog2(MAX_STEP_BYTES);

    localparam logic [7:0]  RUN_LIMIT      = 8'hFF;
    localparam logic [7:0]  ZERO_MARKER    = 8'h00;
    localparam logic [15:0] CAP_RESET      = 16'hFFFF;

    // encoded bytes produced by one input byte, before the capacity check
    typedef struct packed {
        logic [MAX_STEP_BYTES-1:0][7:0] step_bytes;
        logic [IDX_W-1:0]               last_idx;   // index of the final byte of the step
        logic                           pkt_last;   // step closes the packet
    } t_step;

endpackage : zrle_pkg

`default_nettype wire

>>> hdl/zrle_front.sv
// front part: accepts input bytes, tracks the open zero run, builds steps
// depends on zrle_pkg
`default_nettype none

module zrle_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_last_in,
    input  wire logic           i_q_full,
    output logic                o_in_ready,
    output logic                o_push,
    output zrle_pkg::t_step     o_step
);

    logic       r_run_open;
    logic [7:0] r_run_zeros;
    logic       n_run_open;
    logic [7:0] n_run_zeros;
    logic       accept;
    logic       has_bytes;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && has_bytes;

    always_comb begin
        o_step            = '0;
        o_step.pkt_last   = i_last_in;
        has_bytes         = 1'b0;
        n_run_open        = r_run_open;
        n_run_zeros       = r_run_zeros;
        if (i_in_byte == 8'd0) begin
            if (r_run_open && (r_run_zeros != zrle_pkg::RUN_LIMIT)) begin
                // extend the run; flush it only at packet end
                n_run_zeros          = r_run_zeros + 8'd1;
                has_bytes            = i_last_in;
                o_step.step_bytes[0] = zrle_pkg::ZERO_MARKER;
                o_step.step_bytes[1] = r_run_zeros + 8'd1;
                o_step.last_idx      = zrle_pkg::IDX_W'(1);
            end else begin
                // open a fresh run of count zero, first splitting off a full run if one is open
                n_run_open  = 1'b1;
                n_run_zeros = 8'd0;
                has_bytes   = r_run_open || i_last_in;
                o_step.step_bytes[0] = zrle_pkg::ZERO_MARKER;
                o_step.step_bytes[1] = r_run_open ? r_run_zeros : 8'd0;
                if (r_run_open && i_last_in) begin
                    o_step.last_idx = zrle_pkg::IDX_W'(3);
                end else begin
                    o_step.last_idx = zrle_pkg::IDX_W'(1);
                end
            end
        end else begin
            has_bytes   = 1'b1;
            n_run_open  = 1'b0;
            n_run_zeros = 8'd0;
            if (r_run_open) begin
                o_step.step_bytes[0] = zrle_pkg::ZERO_MARKER;
                o_step.step_bytes[1] = r_run_zeros;
                o_step.step_bytes[2] = i_in_byte;
                o_step.last_idx      = zrle_pkg::IDX_W'(2);
            end else begin
                o_step.step_bytes[0] = i_in_byte;
                o_step.last_idx      = zrle_pkg::IDX_W'(0);
            end
        end
        if (i_last_in) begin
            n_run_open  = 1'b0;
            n_run_zeros = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_zeros <= 8'd0;
        end else if (accept) begin
            r_run_open  <= n_run_open;
            r_run_zeros <= n_run_zeros;
        end
    end

endmodule : zrle_front

`default_nettype wire

>>> hdl/zrle_queue.sv
// small step queue between the front and back parts
// depends on zrle_pkg
`default_nettype none

module zrle_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire zrle_pkg::t_step i_step,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output zrle_pkg::t_step     o_step
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    zrle_pkg::t_step r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_step  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule : zrle_queue

`default_nettype wire

>>> hdl/zrle_back.sv
// back part: walks each step byte by byte, applies the capacity, drives the output register
// depends on zrle_pkg
`default_nettype none

module zrle_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_q_valid,
    input  wire zrle_pkg::t_step i_q_step,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_last_out,
    output logic [15:0]         o_encoded_length,
    output logic                o_overflow
);

    logic [15:0]                r_cap;
    logic [15:0]                r_bytes;
    logic                       r_ovf;
    logic [zrle_pkg::IDX_W-1:0] r_idx;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_byte_valid;
    logic                       r_last_out;
    logic [15:0]                r_encoded_length;
    logic                       r_overflow;

    logic [7:0]  cur_byte;
    logic        step_end;
    logic        fits;
    logic        fits_next;
    logic        go;
    logic        load;
    logic        finish;
    logic [15:0] bytes_inc;

    assign cur_byte  = i_q_step.step_bytes[r_idx];
    assign step_end  = (r_idx == i_q_step.last_idx);
    assign fits      = !r_ovf && (r_bytes < r_cap);
    assign bytes_inc = r_bytes + 16'd1;
    assign fits_next = ({1'b0, r_bytes} + 17'd1) < {1'b0, r_cap};
    assign go        = i_q_valid && (!r_out_valid || i_out_ready);
    assign load      = go && (fits || i_q_step.pkt_last);
    assign finish    = go && i_q_step.pkt_last && (!fits || step_end || !fits_next);
    assign o_pop     = go && (step_end || !fits || finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= zrle_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (finish) begin
                r_bytes <= '0;
                r_ovf   <= 1'b0;
                r_idx   <= '0;
            end else if (go) begin
                if (fits) begin
                    r_bytes <= bytes_inc;
                    r_idx   <= step_end ? '0 : r_idx + zrle_pkg::IDX_W'(1);
                end else begin
                    // rest of this step is suppressed
                    r_ovf <= 1'b1;
                    r_idx <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte       <= fits ? cur_byte : 8'd0;
            r_byte_valid     <= fits;
            r_last_out       <= finish;
            r_overflow       <= finish && !(fits && step_end);
            r_encoded_length <= (finish && fits && step_end) ? bytes_inc : 16'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_byte_valid;
    assign o_last_out       = r_last_out;
    assign o_encoded_length = r_encoded_length;
    assign o_overflow       = r_overflow;

    a_status_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last_out && o_overflow)
        else $error("status-only transfer without final overflow marking");

    a_overflow_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_last_out && (o_encoded_length == 16'd0))
        else $error("overflow transfer carries a length or is not final");

    a_idx_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx <= i_q_step.last_idx)
        else $error("byte index ran past the end of the step");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_bytes == 16'd0) && !r_ovf && (r_idx == '0))
        else $error("packet state not cleared after final transfer");

endmodule : zrle_back

`default_nettype wire

>>> hdl/zero_run_length_encoder.sv
// top level of the zero run-length encoder: front, step queue and back part
// depends on zrle_pkg, zrle_front, zrle_queue and zrle_back
//
// Packets enter one byte per transfer, with i_last_in on the final byte. A
// nonzero byte is passed on as a literal; a zero opens a run that counts up
// to 255 further zeros and is sent as a zero marker followed by the count,
// when a nonzero byte arrives, when a zero arrives at a full count, or at packet end.
// The encoded bytes of a packet are counted against the capacity register
// (reset 65535, written through i_cfg_we/i_cfg_data). Once a byte would pass
// it, that byte and the rest of the packet are dropped and the final
// transfer carries o_overflow=1 and o_encoded_length=0; if nothing was left
// to send on the final step, a status-only transfer (o_byte_valid=0) marks
// the end. Otherwise the final transfer carries the packet's length.
// Rate: the front takes one input byte per cycle while the step queue
// (QUEUE_DEPTH steps) has room. Each input byte becomes a step of zero to
// four encoded bytes, and the back part sends one encoded byte per cycle
// while the output is ready. A step holds one byte for a literal, none
// for a zero that extends a run, and two to four when a run is flushed.
// The rest of a step past the capacity is popped and dropped without an
// output byte, unless a byte of the final step has already closed the
// packet. Steps pass through the queue, then the back output register.
`default_nettype none

module zero_run_length_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration write
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_data,
    // input byte channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_last_in,
    // encoded output channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_last_out,
    output logic [15:0]         o_encoded_length,
    output logic                o_overflow
);

    // steps travel from front to back through the queue
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;
    zrle_pkg::t_step front_step;
    zrle_pkg::t_step head_step;

    // front: run tracking and step building
    zrle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_last_in  (i_last_in),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_step     (front_step)
    );

    // queue decouples input stalls from output stalls
    zrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_step  (front_step),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_step  (head_step)
    );

    // back: capacity accounting and registered output
    zrle_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_q_valid        (q_valid),
        .i_q_step         (head_step),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last_out       (o_last_out),
        .o_encoded_length (o_encoded_length),
        .o_overflow       (o_overflow)
    );

endmodule : zero_run_length_encoder

`default_nettype wire
